// File: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Operation codes carried in the op field of an input beat.
    typedef enum logic [1:0] {
        OP_PUT,
        OP_COLOUR,
        OP_CLEAR,
        OP_READ
    } op_t;

    // Classes of a put-character code.
    typedef enum logic [2:0] {
        CH_BS,
        CH_TAB,
        CH_CR,
        CH_NL,
        CH_PRINT,
        CH_OTHER
    } char_class_t;

    // One datapath operation per cycle, issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SET_ATTR,
        DP_ATTR_PROMPT,
        DP_ATTR_DEFAULT,
        DP_HOME,
        DP_GLYPH,
        DP_PROMPT_GLYPH,
        DP_BACKSPACE,
        DP_TAB,
        DP_CR,
        DP_NEWLINE,
        DP_FILL,
        DP_SCROLL_RD,
        DP_SCROLL_WR,
        DP_READ
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_FILL,
        ST_NL_ATTR,
        ST_PROMPT,
        ST_NL_END,
        ST_RESP
    } state_t;

    localparam logic [7:0] CHAR_BS      = 8'h08;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_PROMPT  = 8'h04;
    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;
    localparam int         PROMPT_LEN   = 9;
    localparam int         BS_MIN_COL   = 9;
    localparam int         TAB_STEP     = 8;
    localparam int         POS_W        = 11;
    localparam int         IN_W         = 29;
    localparam int         OUT_W        = 35;
    localparam int         S_TDATA_W    = 32;
    localparam int         M_TDATA_W    = 40;

    // Input item, op in the lowest bits.
    typedef struct packed {
        logic [10:0] cell_index;
        logic [3:0]  back_color;
        logic [3:0]  fore_color;
        logic [7:0]  char_code;
        op_t         op;
    } in_item_t;

    // Result item, cursor_pos in the lowest bits.
    typedef struct packed {
        logic [7:0]  current_attribute;
        logic [15:0] cell_value;
        logic [10:0] cursor_pos;
    } out_item_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t         op;
        char_class_t cls;
        logic        col_gt9;
        logic        col_end;
        logic        tab_wrap;
        logic        row_last;
        logic        ptr_copy_last;
        logic        ptr_last;
        logic        prompt_last;
    } dp_status_t;

    // The prompt text "guest:~$ ".
    function automatic logic [7:0] prompt_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h67;
            4'd1:    c = 8'h75;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h73;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h3A;
            4'd6:    c = 8'h7E;
            4'd7:    c = 8'h24;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_op_t          cmd,
    output logic                     s_tready,
    output logic                     out_load
);

    tcw_pkg::state_t state_reg, state_next;
    // Set while a scroll was started by a newline, so the prompt follows it.
    logic nl_reg, nl_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
            nl_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nl_reg    <= nl_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        nl_next    = nl_reg;
        cmd        = tcw_pkg::DP_NOP;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd = tcw_pkg::DP_FILL;
                if (status.ptr_last) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = tcw_pkg::DP_LOAD;
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                nl_next    = 1'b0;
                state_next = tcw_pkg::ST_RESP;
                case (status.op)
                    tcw_pkg::OP_COLOUR: begin
                        cmd = tcw_pkg::DP_SET_ATTR;
                    end
                    tcw_pkg::OP_CLEAR: begin
                        cmd        = tcw_pkg::DP_HOME;
                        state_next = tcw_pkg::ST_FILL;
                    end
                    tcw_pkg::OP_READ: begin
                        cmd = tcw_pkg::DP_READ;
                    end
                    tcw_pkg::OP_PUT: begin
                        case (status.cls)
                            tcw_pkg::CH_BS: begin
                                if (status.col_gt9) begin
                                    cmd = tcw_pkg::DP_BACKSPACE;
                                end
                            end
                            tcw_pkg::CH_TAB: begin
                                cmd = tcw_pkg::DP_TAB;
                                if (status.tab_wrap && status.row_last) begin
                                    state_next = tcw_pkg::ST_SCR_RD;
                                end
                            end
                            tcw_pkg::CH_CR: begin
                                cmd = tcw_pkg::DP_CR;
                            end
                            tcw_pkg::CH_NL: begin
                                cmd = tcw_pkg::DP_NEWLINE;
                                if (status.row_last) begin
                                    nl_next    = 1'b1;
                                    state_next = tcw_pkg::ST_SCR_RD;
                                end else begin
                                    state_next = tcw_pkg::ST_NL_ATTR;
                                end
                            end
                            tcw_pkg::CH_PRINT: begin
                                cmd = tcw_pkg::DP_GLYPH;
                                if (status.col_end && status.row_last) begin
                                    state_next = tcw_pkg::ST_SCR_RD;
                                end
                            end
                            default: begin
                                cmd = tcw_pkg::DP_NOP;
                            end
                        endcase
                    end
                    default: begin
                        cmd = tcw_pkg::DP_NOP;
                    end
                endcase
            end
            tcw_pkg::ST_FILL: begin
                cmd = tcw_pkg::DP_FILL;
                if (status.ptr_last) begin
                    state_next = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_SCR_RD: begin
                cmd        = tcw_pkg::DP_SCROLL_RD;
                state_next = tcw_pkg::ST_SCR_WR;
            end
            tcw_pkg::ST_SCR_WR: begin
                cmd = tcw_pkg::DP_SCROLL_WR;
                if (status.ptr_copy_last) begin
                    state_next = tcw_pkg::ST_SCR_FILL;
                end else begin
                    state_next = tcw_pkg::ST_SCR_RD;
                end
            end
            tcw_pkg::ST_SCR_FILL: begin
                cmd = tcw_pkg::DP_FILL;
                if (status.ptr_last) begin
                    state_next = nl_reg ? tcw_pkg::ST_NL_ATTR : tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_NL_ATTR: begin
                cmd        = tcw_pkg::DP_ATTR_PROMPT;
                state_next = tcw_pkg::ST_PROMPT;
            end
            tcw_pkg::ST_PROMPT: begin
                cmd = tcw_pkg::DP_PROMPT_GLYPH;
                if (status.prompt_last) begin
                    state_next = tcw_pkg::ST_NL_END;
                end
            end
            tcw_pkg::ST_NL_END: begin
                cmd        = tcw_pkg::DP_ATTR_DEFAULT;
                state_next = tcw_pkg::ST_RESP;
            end
            tcw_pkg::ST_RESP: begin
                if (!m_tvalid || m_tready) begin
                    out_load   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // A newline that hits the bottom row must run the prompt after the scroll.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tcw_pkg::ST_SCR_FILL && status.ptr_last && nl_reg
        |=> state_reg == tcw_pkg::ST_NL_ATTR)
        else $error("newline scroll did not continue with the prompt");

endmodule

`default_nettype wire

// File: design/tcw_datapath.sv
`default_nettype none

module tcw_datapath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcw_pkg::dp_op_t   cmd,
    input  wire tcw_pkg::in_item_t s_item,
    output tcw_pkg::dp_status_t    status,
    output tcw_pkg::out_item_t     result
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW    = AW + tcw_pkg::POS_W;
    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    tcw_pkg::in_item_t item_reg, item_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    attr_reg, attr_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [3:0]    pidx_reg, pidx_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr, pos;
    logic [15:0]   wdata, blank;
    logic [CW:0]   tab_sum, tab_val;
    logic [XW-1:0] idx_wide, pos_wide;
    logic          idx_ok;
    tcw_pkg::char_class_t cls;

    assign pos      = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign blank    = {attr_reg, tcw_pkg::CHAR_SPACE};
    assign tab_sum  = {1'b0, col_reg} + (CW + 1)'(tcw_pkg::TAB_STEP);
    assign tab_val  = {tab_sum[CW:3], 3'b000};
    assign idx_wide = XW'(item_reg.cell_index);
    assign idx_ok   = idx_wide < XW'(CELLS);
    assign pos_wide = XW'(pos);

    always_comb begin
        if (item_reg.char_code == tcw_pkg::CHAR_BS) begin
            cls = tcw_pkg::CH_BS;
        end else if (item_reg.char_code == tcw_pkg::CHAR_TAB) begin
            cls = tcw_pkg::CH_TAB;
        end else if (item_reg.char_code == tcw_pkg::CHAR_CR) begin
            cls = tcw_pkg::CH_CR;
        end else if (item_reg.char_code == tcw_pkg::CHAR_NL) begin
            cls = tcw_pkg::CH_NL;
        end else if (item_reg.char_code >= tcw_pkg::CHAR_SPACE) begin
            cls = tcw_pkg::CH_PRINT;
        end else begin
            cls = tcw_pkg::CH_OTHER;
        end
    end

    always_comb begin
        status.op            = item_reg.op;
        status.cls           = cls;
        status.col_gt9       = col_reg > CW'(tcw_pkg::BS_MIN_COL);
        status.col_end       = col_reg == CW'(COLS - 1);
        status.tab_wrap      = tab_val >= (CW + 1)'(COLS);
        status.row_last      = row_reg == RW'(ROWS - 1);
        status.ptr_copy_last = ptr_reg == AW'(CELLS - COLS - 1);
        status.ptr_last      = ptr_reg == AW'(CELLS - 1);
        status.prompt_last   = pidx_reg == 4'(tcw_pkg::PROMPT_LEN - 1);
    end

    always_comb begin
        item_next = item_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        attr_next = attr_reg;
        ptr_next  = ptr_reg;
        pidx_next = pidx_reg;
        we        = 1'b0;
        waddr     = ptr_reg;
        wdata     = blank;
        re        = 1'b0;
        raddr     = ptr_reg + COLS_A;
        case (cmd)
            tcw_pkg::DP_LOAD: begin
                item_next = s_item;
            end
            tcw_pkg::DP_SET_ATTR: begin
                attr_next = {item_reg.back_color, item_reg.fore_color};
            end
            tcw_pkg::DP_ATTR_PROMPT: begin
                attr_next = tcw_pkg::ATTR_PROMPT;
            end
            tcw_pkg::DP_ATTR_DEFAULT: begin
                attr_next = tcw_pkg::ATTR_DEFAULT;
            end
            tcw_pkg::DP_HOME: begin
                col_next = '0;
                row_next = '0;
            end
            tcw_pkg::DP_GLYPH, tcw_pkg::DP_PROMPT_GLYPH: begin
                we    = 1'b1;
                waddr = pos;
                if (cmd == tcw_pkg::DP_PROMPT_GLYPH) begin
                    wdata     = {attr_reg, tcw_pkg::prompt_char(pidx_reg)};
                    pidx_next = status.prompt_last ? 4'd0 : pidx_reg + 4'd1;
                end else begin
                    wdata = {attr_reg, item_reg.char_code};
                end
                if (status.col_end) begin
                    col_next = '0;
                    if (!status.row_last) begin
                        row_next = row_reg + RW'(1);
                    end
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            tcw_pkg::DP_BACKSPACE: begin
                we       = 1'b1;
                waddr    = pos - AW'(1);
                col_next = col_reg - CW'(1);
            end
            tcw_pkg::DP_TAB: begin
                if (status.tab_wrap) begin
                    col_next = '0;
                    if (!status.row_last) begin
                        row_next = row_reg + RW'(1);
                    end
                end else begin
                    col_next = tab_val[CW-1:0];
                end
            end
            tcw_pkg::DP_CR: begin
                col_next = '0;
            end
            tcw_pkg::DP_NEWLINE: begin
                col_next = '0;
                if (!status.row_last) begin
                    row_next = row_reg + RW'(1);
                end
            end
            tcw_pkg::DP_FILL: begin
                we       = 1'b1;
                ptr_next = status.ptr_last ? '0 : ptr_reg + AW'(1);
            end
            tcw_pkg::DP_SCROLL_RD: begin
                re = 1'b1;
            end
            tcw_pkg::DP_SCROLL_WR: begin
                we       = 1'b1;
                wdata    = rdata_reg;
                ptr_next = ptr_reg + AW'(1);
            end
            tcw_pkg::DP_READ: begin
                re    = idx_ok;
                raddr = idx_wide[AW-1:0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            attr_reg <= tcw_pkg::ATTR_DEFAULT;
            ptr_reg  <= '0;
            pidx_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            attr_reg <= attr_next;
            ptr_reg  <= ptr_next;
            pidx_reg <= pidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb begin
        result.cursor_pos        = pos_wide[tcw_pkg::POS_W-1:0];
        result.current_attribute = attr_reg;
        if (item_reg.op == tcw_pkg::OP_READ && idx_ok) begin
            result.cell_value = rdata_reg;
        end else begin
            result.cell_value = '0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == tcw_pkg::DP_NEWLINE && !status.row_last
        |=> row_reg == $past(row_reg) + RW'(1) && col_reg == '0)
        else $error("newline did not advance the row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == tcw_pkg::DP_FILL && status.ptr_last |=> ptr_reg == '0)
        else $error("fill pointer did not return to zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == tcw_pkg::DP_PROMPT_GLYPH && status.prompt_last
        |=> col_reg == CW'(tcw_pkg::PROMPT_LEN))
        else $error("prompt did not leave the cursor after its last character");

endmodule

`default_nettype wire

// File: design/text_console_writer_core.sv
// Text console writer: keeps a COLS x ROWS screen of 16-bit cells (attribute
// in the high byte, character in the low byte), a cursor and a current
// attribute. Each beat on the s_ channel carries one operation: put
// character, set colour, clear screen or read cell. Each operation yields
// exactly one beat on the m_ channel with the linear cursor position, the
// cell read (zero for the other operations) and the attribute in use.
// The block works on one operation at a time. Clear screen writes one cell
// per cycle. A scroll copies every cell up by one row with a read and then
// a write, then blanks the bottom row.
// After reset the screen is blanked to white-on-black spaces by a clearing
// pass over all COLS*ROWS cells, during which s_tready stays low.
// The result is held in an output register, so when the receiver stalls
// the next operation can still be accepted and worked on; it then waits
// until the earlier result beat has been taken.

`default_nettype none

module text_console_writer_core #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // op [1:0], char_code [9:2], fore_color [13:10], back_color [17:14],
    // cell_index [28:18], zero fill above
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // cursor_pos [10:0], cell_value [26:11], current_attribute [34:27],
    // zero fill above
    output logic [tcw_pkg::M_TDATA_W-1:0]        m_tdata
);

    tcw_pkg::dp_op_t    cmd;
    tcw_pkg::dp_status_t status;
    tcw_pkg::in_item_t  s_item;
    tcw_pkg::out_item_t result;
    logic               out_load;

    // Output register: decouples the result beat from the operation engine.
    logic               m_valid_reg, m_valid_next;
    tcw_pkg::out_item_t m_data_reg;

    assign s_item = tcw_pkg::in_item_t'(s_tdata[tcw_pkg::IN_W-1:0]);

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tvalid (m_valid_reg),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .out_load (out_load)
    );

    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .status  (status),
        .result  (result)
    );

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(tcw_pkg::M_TDATA_W - tcw_pkg::OUT_W)'(0), m_data_reg};

    // One operation at a time: the cycle after an accepted beat never accepts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is in progress");

    // A result is only loaded when the output register is free to take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !out_load)
        else $error("result loaded over a stalled beat");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for text_console_writer_core.
//
// Operations are sent as beats on the s_ channel. A behavioural copy of the
// console runs beside the block: it keeps its own screen, cursor and
// attribute. Each accepted input beat updates that copy, and the copy's
// answer goes into a queue. Every result beat on the m_ channel is checked
// against the oldest answer in the queue, field by field.
//
// Both channels pause for a random number of cycles before each beat. There
// are also stretches in which a side never pauses. A watchdog ends the run
// if no beat moves for far longer than the slowest operation, which is a
// newline that scrolls, needs.

module tb_top;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLS * ROWS;
    localparam int MAX_WAIT     = 13;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 70;
    localparam int MAX_REPORTS  = 10;
    localparam logic [8*tcw_pkg::PROMPT_LEN-1:0] PROMPT_TEXT = "guest:~$ ";

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata;

    text_console_writer_core #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The testbench's own copy of the console state.
    logic [15:0]  screen [0:CELLS-1];
    int unsigned  cur_col;
    int unsigned  cur_row;
    logic [7:0]   cur_attr;

    // Results worked out from accepted beats, oldest first.
    tcw_pkg::out_item_t pending_replies [$];
    int unsigned  fail_count  = 0;
    int unsigned  items_sent  = 0;
    int unsigned  idle_cycles = 0;

    // When set, that side never pauses between beats.
    bit           s_steady = 1'b0;
    bit           m_steady = 1'b0;

    // ------------------------------------------------------------------
    // Console behaviour
    // ------------------------------------------------------------------

    function automatic void screen_reset();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CHAR_SPACE};
        end
        cur_col  = 0;
        cur_row  = 0;
        cur_attr = tcw_pkg::ATTR_DEFAULT;
    endfunction

    // Once the row runs past the bottom, every line moves up by one and the
    // new bottom line is blanked in the attribute in use at that moment.
    function automatic void scroll_up();
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) begin
                screen[i] = screen[i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++) begin
                screen[i] = {cur_attr, tcw_pkg::CHAR_SPACE};
            end
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void wrap_line();
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
        end
        scroll_up();
    endfunction

    function automatic void store_glyph(input logic [7:0] code);
        int unsigned idx;
        idx = cur_row * COLS + cur_col;
        if (idx < CELLS) begin
            screen[idx] = {cur_attr, code};
        end
        cur_col++;
        wrap_line();
    endfunction

    function automatic void put_code(input logic [7:0] code);
        int unsigned idx;
        case (code)
            tcw_pkg::CHAR_BS: begin
                // The prompt occupies the first columns and is never erased.
                if (cur_col > tcw_pkg::BS_MIN_COL) begin
                    cur_col--;
                    idx = cur_row * COLS + cur_col;
                    if (idx < CELLS) begin
                        screen[idx] = {cur_attr, tcw_pkg::CHAR_SPACE};
                    end
                end
                wrap_line();
            end
            tcw_pkg::CHAR_TAB: begin
                cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
                wrap_line();
            end
            tcw_pkg::CHAR_CR: begin
                cur_col = 0;
                wrap_line();
            end
            tcw_pkg::CHAR_NL: begin
                cur_col = 0;
                cur_row++;
                scroll_up();
                cur_attr = tcw_pkg::ATTR_PROMPT;
                for (int i = 0; i < tcw_pkg::PROMPT_LEN; i++) begin
                    store_glyph(PROMPT_TEXT[8*(tcw_pkg::PROMPT_LEN-1-i) +: 8]);
                end
                cur_attr = tcw_pkg::ATTR_DEFAULT;
                wrap_line();
            end
            default: begin
                // Codes from the space upwards are printable; the remaining
                // control codes leave everything as it was.
                if (code >= tcw_pkg::CHAR_SPACE) begin
                    store_glyph(code);
                end else begin
                    wrap_line();
                end
            end
        endcase
    endfunction

    function automatic tcw_pkg::out_item_t console_apply(input tcw_pkg::in_item_t item);
        tcw_pkg::out_item_t reply;
        int unsigned        pos;
        reply = '0;
        case (item.op)
            tcw_pkg::OP_PUT: begin
                put_code(item.char_code);
            end
            tcw_pkg::OP_COLOUR: begin
                cur_attr = {item.back_color, item.fore_color};
            end
            tcw_pkg::OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i] = {cur_attr, tcw_pkg::CHAR_SPACE};
                end
                cur_col = 0;
                cur_row = 0;
            end
            default: begin
                // Indexes past the end of the screen read as zero.
                if (item.cell_index < CELLS) begin
                    reply.cell_value = screen[item.cell_index];
                end
            end
        endcase
        pos = cur_row * COLS + cur_col;
        reply.cursor_pos        = pos[tcw_pkg::POS_W-1:0];
        reply.current_attribute = cur_attr;
        return reply;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one beat and records the result that it should produce. The
    // valid line is left high after acceptance, so that back-to-back beats
    // never lower and raise it within the same time step.
    task automatic send_item(input tcw_pkg::in_item_t item);
        int unsigned gap;
        gap = s_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tcw_pkg::S_TDATA_W-tcw_pkg::IN_W){1'b0}}, item};
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(console_apply(item));
        items_sent++;
    endtask

    // Fields that an operation does not use carry random values, so that
    // every bit of the beat moves.
    function automatic tcw_pkg::in_item_t noise_item();
        logic [31:0] bits;
        bits = $urandom;
        return bits[tcw_pkg::IN_W-1:0];
    endfunction

    task automatic do_put(input logic [7:0] code);
        tcw_pkg::in_item_t item;
        item           = noise_item();
        item.op        = tcw_pkg::OP_PUT;
        item.char_code = code;
        send_item(item);
    endtask

    task automatic do_colour(input logic [3:0] fore, input logic [3:0] back);
        tcw_pkg::in_item_t item;
        item            = noise_item();
        item.op         = tcw_pkg::OP_COLOUR;
        item.fore_color = fore;
        item.back_color = back;
        send_item(item);
    endtask

    task automatic do_clear();
        tcw_pkg::in_item_t item;
        item    = noise_item();
        item.op = tcw_pkg::OP_CLEAR;
        send_item(item);
    endtask

    // The index is taken modulo the width of the cell_index field.
    task automatic do_read(input int unsigned idx);
        tcw_pkg::in_item_t item;
        item            = noise_item();
        item.op         = tcw_pkg::OP_READ;
        item.cell_index = idx[tcw_pkg::POS_W-1:0];
        send_item(item);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the check of every beat
    // ------------------------------------------------------------------

    initial begin : reply_side
        int unsigned        gap;
        tcw_pkg::out_item_t got;
        tcw_pkg::out_item_t want;
        forever begin
            gap = m_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
            got = m_tdata[tcw_pkg::OUT_W-1:0];
            if (pending_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result beat: pos %0d cell %h attr %h",
                             got.cursor_pos, got.cell_value, got.current_attribute);
                end
            end else begin
                want = pending_replies.pop_front();
                if (got.cursor_pos !== want.cursor_pos ||
                    got.cell_value !== want.cell_value ||
                    got.current_attribute !== want.current_attribute) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display({"mismatch: expected pos %0d cell %h attr %h, ",
                                  "got pos %0d cell %h attr %h"},
                                 want.cursor_pos, want.cell_value, want.current_attribute,
                                 got.cursor_pos, got.cell_value, got.current_attribute);
                    end
                end
            end
        end
    end

    // Ends the run when no beat has moved on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The screen must come out of reset as white-on-black spaces, and reads
    // past the last cell must return zero.
    task automatic test_reset_screen();
        do_read(0);
        do_read(CELLS - 1);
        do_read(CELLS);
        do_read((1 << tcw_pkg::POS_W) - 1);
    endtask

    // Extreme attributes, the top printable character FF and the character 7F.
    task automatic test_colours();
        do_colour(4'hF, 4'hF);
        do_put(8'hFF);
        do_colour(4'h0, 4'h0);
        do_put(8'h7F);
        do_colour(4'hF, 4'h0);
        do_read(1);
    endtask

    // Ignored control codes, a backspace that the prompt guard blocks, a tab
    // and a carriage return.
    task automatic test_control_codes();
        do_put(8'h00);
        do_put(8'h1F);
        do_put(tcw_pkg::CHAR_BS);
        do_put(tcw_pkg::CHAR_TAB);
        do_put(tcw_pkg::CHAR_CR);
    endtask

    // A newline writes the prompt; a backspace at its end is blocked, while
    // one after a typed character erases it.
    task automatic test_newline_prompt();
        do_put(tcw_pkg::CHAR_NL);
        do_put(tcw_pkg::CHAR_BS);
        do_put(8'h41);
        do_put(tcw_pkg::CHAR_BS);
        do_read(COLS);
    endtask

    // Clearing fills the screen with spaces in the attribute then in use.
    task automatic test_clear();
        do_colour(4'h3, 4'hA);
        do_clear();
        do_read(CELLS - 1);
    endtask

    // Newlines down to the bottom row, then scrolls caused by a newline and
    // by a run of tabs that passes the line end.
    task automatic test_scroll();
        s_steady = 1'b0;
        m_steady = 1'b1;
        while (cur_row < ROWS - 1) begin
            do_put(tcw_pkg::CHAR_NL);
            if ($urandom_range(0, 1)) begin
                do_put(8'($urandom_range(32, 255)));
            end
        end
        m_steady = 1'b0;
        do_colour(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        do_put(tcw_pkg::CHAR_NL);
        do_read((ROWS - 1) * COLS + $urandom_range(tcw_pkg::PROMPT_LEN, COLS - 1));
        do_read((ROWS - 2) * COLS + $urandom_range(0, tcw_pkg::PROMPT_LEN - 1));
        do_colour(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        do do_put(tcw_pkg::CHAR_TAB); while (cur_col != 0);
        do_read((ROWS - 1) * COLS + $urandom_range(0, COLS - 1));
        do_read((ROWS - 2) * COLS + $urandom_range(COLS - 8, COLS - 1));
    endtask

    // Mostly typing with prompts, edits and reads near the cursor, with the
    // odd colour change, clear and stray control code mixed in.
    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned kind;
        int unsigned pos;
        logic [7:0]  code;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            // Now and then, switch to a stretch in which a side never waits.
            if ($urandom_range(0, 24) == 0) begin
                s_steady = ($urandom_range(0, 3) == 0);
                m_steady = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                do_put(8'($urandom_range(32, 255)));
            end else if (kind < 48) begin
                do_put(tcw_pkg::CHAR_NL);
            end else if (kind < 54) begin
                do_put(tcw_pkg::CHAR_BS);
            end else if (kind < 60) begin
                repeat ($urandom_range(1, 10)) do_put(tcw_pkg::CHAR_TAB);
            end else if (kind < 63) begin
                do_put(tcw_pkg::CHAR_CR);
            end else if (kind < 66) begin
                do begin
                    code = 8'($urandom_range(0, 31));
                end while (code == tcw_pkg::CHAR_BS || code == tcw_pkg::CHAR_TAB ||
                           code == tcw_pkg::CHAR_NL || code == tcw_pkg::CHAR_CR);
                do_put(code);
            end else if (kind < 74) begin
                do_colour(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end else if (kind < 76) begin
                do_clear();
            end else begin
                pos = cur_row * COLS + cur_col;
                case ($urandom_range(0, 3))
                    0: do_read($urandom_range(0, (1 << tcw_pkg::POS_W) - 1));
                    1: do_read(pos >= 16 ? pos - $urandom_range(1, 16) : pos);
                    2: do_read(cur_row * COLS + $urandom_range(0, tcw_pkg::PROMPT_LEN));
                    default: do_read((ROWS - 1) * COLS + $urandom_range(0, COLS - 1));
                endcase
            end
        end
    endtask

    initial begin
        screen_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_screen();
        test_colours();
        test_control_codes();
        test_newline_prompt();
        test_clear();
        test_scroll();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
